// ===== rtl/clipped_tile_blit_address_generator_macros.svh =====
// ----------------------------------------------------------------------------
// clipped tile blit address generator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef CLIPPED_TILE_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define CLIPPED_TILE_BLIT_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication
`define CTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctbag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbag_pkg
// shared types and constants of the clipped tile blit address generator
// ----------------------------------------------------------------------------
package ctbag_pkg;

    // tile index width, covers tiles up to 8 x 8
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 10;
    localparam int CODE_W = 8;

    typedef struct packed {
        logic              mode;
        logic signed [7:0] x_pos;
        logic signed [7:0] y_pos;
        logic [7:0]        code;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [CODE_W-1:0] char_code;
        logic              last;
    } out_item_t;

    // visible window of one item, indexes inside the tile
    typedef struct packed {
        logic [IDX_W-1:0]  c0;
        logic [IDX_W-1:0]  c1;
        logic [IDX_W-1:0]  r0;
        logic [IDX_W-1:0]  r1;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
    } desc_t;

endpackage

// ===== rtl/ctbag_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbag_front
// clips an item against the buffer and builds its visible-window descriptor
// ----------------------------------------------------------------------------
module ctbag_front #(
    parameter int COLS = 24,
    parameter int ROWS = 24,
    parameter int TILE = 6
) (
    input  ctbag_pkg::in_item_t item,
    output logic                visible,
    output ctbag_pkg::desc_t    desc
);
    import ctbag_pkg::*;

    localparam logic signed [9:0] COL_MAX  = 10'(COLS - 1);
    localparam logic signed [9:0] ROW_MAX  = 10'(ROWS - 1);
    localparam logic signed [9:0] TILE_M1  = 10'(TILE - 1);
    localparam logic [12:0]       COLS_13  = 13'(COLS);
    localparam logic [7:0]        TILE_8   = 8'(TILE);

    logic signed [9:0] xs;
    logic signed [9:0] ys;
    logic signed [9:0] size_m1;
    logic signed [9:0] x_end;
    logic signed [9:0] y_end;
    logic signed [9:0] x_neg;
    logic signed [9:0] y_neg;
    logic signed [9:0] c1_full;
    logic signed [9:0] r1_full;
    logic signed [9:0] col0;
    logic signed [9:0] row0;
    logic [IDX_W-1:0]  c0;
    logic [IDX_W-1:0]  r0;
    logic [12:0]       row_base;
    logic [12:0]       addr_full;

    always_comb
    begin
        xs      = {{2{item.x_pos[7]}}, item.x_pos};
        ys      = {{2{item.y_pos[7]}}, item.y_pos};
        size_m1 = item.mode ? TILE_M1 : 10'sd0;
        x_end   = xs + size_m1;
        y_end   = ys + size_m1;
        visible = (xs <= COL_MAX) && (x_end >= 0) && (ys <= ROW_MAX) && (y_end >= 0);

        // first visible column / row inside the tile
        x_neg = -xs;
        y_neg = -ys;
        c0    = (xs < 0) ? x_neg[IDX_W-1:0] : '0;
        r0    = (ys < 0) ? y_neg[IDX_W-1:0] : '0;

        // last visible column / row inside the tile
        c1_full = (x_end > COL_MAX) ? (COL_MAX - xs) : size_m1;
        r1_full = (y_end > ROW_MAX) ? (ROW_MAX - ys) : size_m1;

        col0      = xs + 10'($unsigned(c0));
        row0      = ys + 10'($unsigned(r0));
        row_base  = 13'(row0[6:0]) * COLS_13;
        addr_full = row_base + 13'(col0[6:0]);

        desc.c0   = c0;
        desc.c1   = c1_full[IDX_W-1:0];
        desc.r0   = r0;
        desc.r1   = r1_full[IDX_W-1:0];
        desc.addr = addr_full[ADDR_W-1:0];
        desc.code = item.code + 8'(r0) * TILE_8 + 8'(c0);
    end

endmodule

// ===== rtl/ctbag_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbag_queue
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module ctbag_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ctbag_pkg::desc_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_valid,
    output ctbag_pkg::desc_t rd_data
);
    import ctbag_pkg::*;

    desc_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_wr;
    logic        do_rd;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        rd_valid    = (count_reg != 2'd0);
        rd_data     = mem_reg[rd_ptr_reg];
        do_wr       = wr_en && !full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ctbag_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbag_back
// walks the visible window row by row and drives the result register
// ----------------------------------------------------------------------------
module ctbag_back #(
    parameter int COLS = 24,
    parameter int TILE = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ctbag_pkg::desc_t     q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output ctbag_pkg::out_item_t result
);
    import ctbag_pkg::*;

    `include "clipped_tile_blit_address_generator_macros.svh"

    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLS);
    localparam logic [CODE_W-1:0] TILE_C = CODE_W'(TILE);

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  c_reg, c_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  c0_reg, c0_next;
    logic [IDX_W-1:0]  c1_reg, c1_next;
    logic [IDX_W-1:0]  r1_reg, r1_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CODE_W-1:0] row_code_reg, row_code_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              advance;
    logic              row_end;
    logic              is_last;

    always_comb
    begin
        busy_next      = busy_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        r1_next        = r1_reg;
        addr_next      = addr_reg;
        row_addr_next  = row_addr_reg;
        code_next      = code_reg;
        row_code_next  = row_code_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        advance = busy_reg && (!out_valid_reg || pop);
        row_end = (c_reg == c1_reg);
        is_last = row_end && (r_reg == r1_reg);
        q_pop   = q_valid && !busy_reg;

        if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            busy_next     = 1'b1;
            c_next        = q_data.c0;
            r_next        = q_data.r0;
            c0_next       = q_data.c0;
            c1_next       = q_data.c1;
            r1_next       = q_data.r1;
            addr_next     = q_data.addr;
            row_addr_next = q_data.addr;
            code_next     = q_data.code;
            row_code_next = q_data.code;
        end
        else if (advance)
        begin
            out_valid_next    = 1'b1;
            out_next.address  = addr_reg;
            out_next.char_code = code_reg;
            out_next.last     = is_last;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else if (row_end)
            begin
                // next row restarts at the first visible column
                c_next        = c0_reg;
                r_next        = r_reg + IDX_W'(1);
                row_addr_next = row_addr_reg + COLS_A;
                addr_next     = row_addr_reg + COLS_A;
                row_code_next = row_code_reg + TILE_C;
                code_next     = row_code_reg + TILE_C;
            end
            else
            begin
                c_next    = c_reg + IDX_W'(1);
                addr_next = addr_reg + ADDR_W'(1);
                code_next = code_reg + CODE_W'(1);
            end
        end

        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        r_reg        <= r_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        r1_reg       <= r1_next;
        addr_reg     <= addr_next;
        row_addr_reg <= row_addr_next;
        code_reg     <= code_next;
        row_code_reg <= row_code_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CTB_ASSERT_NOW(a_walk_in_window, busy_reg, (c_reg <= c1_reg) && (r_reg <= r1_reg), "walker left its window")
    `CTB_ASSERT_NEXT(a_more_after_mid, advance && !is_last, busy_reg, "walker stopped before last cell")
    `CTB_ASSERT_NEXT(a_idle_after_last, advance && is_last, !busy_reg && out_reg.last, "walker kept going after last cell")
    `CTB_ASSERT_NOW(a_no_load_while_busy, busy_reg, !q_pop, "descriptor taken while busy")

endmodule

// ===== rtl/clipped_tile_blit_address_generator.sv =====
`timescale 1ns / 1ps
// path: the first write of an accepted transaction goes through the queue, the walker load and the
//   result register before it shows on result; the back walker then emits one write per cycle
//   while pop keeps up, and loads a new item only after the last write of the one before
// the back walker (one cell per cycle while result is not held) sets the rate; a two-entry queue decouples it
// reset: asynchronous, active low; clears queue, walker and result valid
// ----------------------------------------------------------------------------
// clipped_tile_blit_address_generator
// clips a cell or tile against a COLS x ROWS character buffer and emits one
// address / code write per visible cell in row-major order
// ----------------------------------------------------------------------------
module clipped_tile_blit_address_generator #(
    parameter int COLS = 24,
    parameter int ROWS = 24,
    parameter int TILE = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input side: queue-style push / full
    input  logic                 push,
    output logic                 full,
    input  ctbag_pkg::in_item_t  item,
    // result side: queue-style empty / pop
    output logic                 empty,
    input  logic                 pop,
    output ctbag_pkg::out_item_t result
);
    import ctbag_pkg::*;

    logic  visible;
    desc_t front_desc;
    logic  q_valid;
    logic  q_pop;
    desc_t q_data;
    logic  q_wr;

    // front: combinational clip of the incoming transaction
    ctbag_front #(
        .COLS (COLS),
        .ROWS (ROWS),
        .TILE (TILE)
    ) u_front (
        .item    (item),
        .visible (visible),
        .desc    (front_desc)
    );

    // fully clipped transactions are accepted and dropped here
    assign q_wr = push && visible;

    // queue between front and back; full stalls every push, clipped or not
    ctbag_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (front_desc),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    // back: walks visible cells, holds the result register
    ctbag_back #(
        .COLS (COLS),
        .TILE (TILE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the clipped tile blit address generator: items go
// in through the push / full side, each write that pops out is compared with
// a behavioral clip-and-walk predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
    import ctbag_pkg::*;

    localparam int COLS        = 24;
    localparam int ROWS        = 24;
    localparam int TILE        = 6;
    // settle well past the result latency
    localparam int SETTLE      = 50;
    // worst case: every item a full tile, every write behind a long stall
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PRINT_CAP   = 40;

    localparam logic MODE_CELL = 1'b0;
    localparam logic MODE_TILE = 1'b1;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // writes predicted for accepted transactions, oldest first
    out_item_t   pending_writes[$];
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    // long receiver hold requested by a test, cleared by the drain process once it has elapsed
    int unsigned hold_off_cycles = 0;
    // random gaps on both sides only while this is set
    bit          idle_on         = 1'b1;

    clipped_tile_blit_address_generator #(
        .COLS (COLS),
        .ROWS (ROWS),
        .TILE (TILE)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs or drops writes
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d writes still expected",
                     cycle_count, pending_writes.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // gap length in cycles: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // clip the cell or tile against the buffer and queue one write per
    // visible cell in row-major order; clipped cells still advance the code
    function automatic void clip_tile_writes(input in_item_t it);
        out_item_t cells[$];
        out_item_t w;
        int        span;
        int        col;
        int        row;
        span = (it.mode == MODE_TILE) ? TILE : 1;
        for (int r = 0; r < span; r++)
        begin
            for (int c = 0; c < span; c++)
            begin
                col = $signed(it.x_pos) + c;
                row = $signed(it.y_pos) + r;
                if (col >= 0 && col < COLS && row >= 0 && row < ROWS)
                begin
                    w.address   = ADDR_W'(row * COLS + col);
                    w.char_code = CODE_W'(int'(it.code) + r * TILE + c);
                    w.last      = 1'b0;
                    cells.push_back(w);
                end
            end
        end
        // only the final visible cell carries last, a fully clipped item adds nothing
        if (cells.size() != 0)
            cells[cells.size() - 1].last = 1'b1;
        foreach (cells[i])
            pending_writes.push_back(cells[i]);
    endfunction

    function automatic in_item_t blit(input logic m, input int x, input int y,
                                      input int code);
        in_item_t it;
        it.mode  = m;
        it.x_pos = 8'(x);
        it.y_pos = 8'(y);
        it.code  = 8'(code);
        return it;
    endfunction

    // offer one transaction and hold it until the block takes it; push stays
    // high into the next call when no gap follows
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        clip_tile_writes(it);
        gap = pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: random pop gaps, plus the long hold when a test asks for it
    initial
    begin : result_drain
        int unsigned gap;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                pop <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                pop <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    // every popped write against the oldest prediction, field by field
    always @(posedge clk)
    begin : write_checker
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected write addr %0d code %0d last %0b",
                                          result.address, result.char_code, result.last));
            else
            begin
                want = pending_writes.pop_front();
                if (result.address !== want.address)
                    report_mismatch($sformatf("address got %0d want %0d",
                                              result.address, want.address));
                if (result.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code got %0d want %0d at addr %0d",
                                              result.char_code, want.char_code,
                                              want.address));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b at addr %0d",
                                              result.last, want.last, want.address));
            end
        end
    end

    // single cells on the buffer corners, just outside each edge, and at the
    // extremes of position and code
    task automatic test_single_cells();
        send_item(blit(MODE_CELL, 0, 0, 0));
        send_item(blit(MODE_CELL, COLS - 1, 0, 255));
        send_item(blit(MODE_CELL, 0, ROWS - 1, 128));
        send_item(blit(MODE_CELL, COLS - 1, ROWS - 1, 127));
        send_item(blit(MODE_CELL, -1, 0, 1));
        send_item(blit(MODE_CELL, COLS, 5, 2));
        send_item(blit(MODE_CELL, 5, -1, 3));
        send_item(blit(MODE_CELL, 5, ROWS, 4));
        send_item(blit(MODE_CELL, -128, 127, 85));
        send_item(blit(MODE_CELL, 127, -128, 170));
    endtask

    // tiles fully inside, clipped on each side and corner, and fully outside
    task automatic test_tiles_directed();
        send_item(blit(MODE_TILE, 0, 0, 250));
        send_item(blit(MODE_TILE, COLS - TILE, ROWS - TILE, 255));
        send_item(blit(MODE_TILE, -3, 2, 10));
        send_item(blit(MODE_TILE, 4, -5, 20));
        send_item(blit(MODE_TILE, COLS - 3, 10, 230));
        send_item(blit(MODE_TILE, 10, ROWS - 2, 40));
        send_item(blit(MODE_TILE, -5, -5, 0));
        send_item(blit(MODE_TILE, COLS - 1, ROWS - 1, 200));
        send_item(blit(MODE_TILE, -TILE, 0, 50));
        send_item(blit(MODE_TILE, COLS, 0, 60));
        send_item(blit(MODE_TILE, -128, -128, 70));
        send_item(blit(MODE_TILE, 127, 127, 80));
        send_item(blit(MODE_TILE, 9, 9, 255));
    endtask

    // receiver holds off while the sender streams full tiles, so the block
    // backs up and raises full
    task automatic test_backpressure();
        idle_on         = 1'b0;
        hold_off_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_item(blit(MODE_TILE, $urandom_range(0, COLS - TILE),
                           $urandom_range(0, ROWS - TILE), $urandom_range(0, 255)));
        wait (hold_off_cycles == 0);
        idle_on = 1'b1;
    endtask

    // mostly tiles and cells around the buffer so clipping is hit from every
    // side, the rest anywhere in the full signed range
    task automatic test_random_blits(input int unsigned count);
        in_item_t    it;
        int unsigned roll;
        for (int unsigned i = 0; i < count; i++)
        begin
            // switch between idling and back-to-back stretches
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 85)
                it = blit((roll < 60) ? MODE_TILE : MODE_CELL,
                          int'($urandom_range(0, COLS + 14)) - 8,
                          int'($urandom_range(0, ROWS + 14)) - 8,
                          $urandom_range(0, 255));
            else
            begin
                it.mode  = 1'($urandom);
                it.x_pos = 8'($urandom);
                it.y_pos = 8'($urandom);
                it.code  = 8'($urandom);
            end
            send_item(it);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cells();
        test_tiles_directed();
        test_backpressure();
        test_random_blits(400);

        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ctbag_pkg.sv
rtl/ctbag_front.sv
rtl/ctbag_queue.sv
rtl/ctbag_back.sv
rtl/clipped_tile_blit_address_generator.sv
sim/tb_top.sv
